/* rtl/omwc_pkg.sv */
// Shared types, widths, codes and defaults for the onset window capture block.
// No dependencies; the analyzer and the top level use it through scoped names.
package omwc_pkg;

   // default sizes for the top-level parameters
   localparam int CHANNELS_DEF    = 12;
   localparam int STORE_DEPTH_DEF = 64;
   localparam int SAMPLE_BITS_DEF = 16;

   // fixed field widths
   localparam int THR_W      = 9;
   localparam int SCAN_W     = 6;
   localparam int WIN_W      = 6;
   localparam int CHN_W      = 4;
   localparam int POS_W      = 6;
   localparam int IO_SAMPLE_W = 16;
   localparam int START_W    = 5;
   localparam int LEN_W      = 7;
   localparam int START_SPAN = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   // register reset values
   localparam logic [THR_W-1:0]  THR_RESET     = 9'd102;
   localparam logic [SCAN_W-1:0] SCAN_RESET    = 6'd30;
   localparam logic [WIN_W-1:0]  WIN_RESET     = 6'd30;
   localparam logic [CHN_W-1:0]  WATCHED_RESET = 4'd6;
   localparam logic [CHN_W-1:0]  NEEDED_RESET  = 4'd2;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SCAN      = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WATCHED   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_NEEDED    = 3'd4;

   // request opcodes and result kinds
   localparam logic OP_LOAD       = 1'b0;
   localparam logic OP_READ       = 1'b1;
   localparam logic KIND_ANALYSIS = 1'b0;
   localparam logic KIND_READ     = 1'b1;

   typedef struct packed {
      logic [THR_W-1:0]  threshold_fraction;
      logic [SCAN_W-1:0] scan_length;
      logic [WIN_W-1:0]  window_length;
      logic [CHN_W-1:0]  channels_watched;
      logic [CHN_W-1:0]  channels_needed;
   } cfg_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic               found;
      logic [START_W-1:0] start;
   } ana_status_type;

endpackage

/* rtl/omwc_store.sv */
// Sample store: one write port, one read port, registered read data.
// Does not use omwc_pkg.
module omwc_store #(
   parameter int CHANNELS    = 12,
   parameter int STORE_DEPTH = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_data
);
   localparam int CH_W   = $clog2(CHANNELS);
   localparam int COL_W  = $clog2(STORE_DEPTH);
   localparam int ADDR_W = CH_W + COL_W;
   localparam int DEPTH  = CHANNELS << COL_W;

   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/omwc_analyzer.sv */
// Record analysis sequencer: range pass, onset pass, onset histogram sweep.
// Reads the sample store through one read port; uses omwc_pkg types.
module omwc_analyzer #(
   parameter int CHANNELS    = 12,
   parameter int STORE_DEPTH = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  omwc_pkg::cfg_type               cfg,
   input  logic [omwc_pkg::LEN_W-1:0]      loaded_length,
   output logic                            rd_en,
   output logic [ADDR_W-1:0]               rd_addr,
   input  logic signed [SAMPLE_BITS-1:0]   rd_data,
   output omwc_pkg::ana_status_type        status
);
   localparam int CH_W   = $clog2(CHANNELS);
   localparam int COL_W  = $clog2(STORE_DEPTH);
   localparam int ADDR_W = CH_W + COL_W;
   localparam int CNT_W  = $clog2(CHANNELS + 1);
   localparam int PROD_W = SAMPLE_BITS + omwc_pkg::THR_W;
   localparam int SPAN_W = $clog2(omwc_pkg::START_SPAN);
   localparam int SCAN_W = omwc_pkg::SCAN_W;
   localparam int LEN_W  = omwc_pkg::LEN_W;

   typedef enum logic [7:0] {
      A_IDLE   = 8'b0000_0001,
      A_CHAN   = 8'b0000_0010,
      A_READ   = 8'b0000_0100,
      A_UPDATE = 8'b0000_1000,
      A_NEXT   = 8'b0001_0000,
      A_SCALE  = 8'b0010_0000,
      A_SWEEP  = 8'b0100_0000,
      A_DONE   = 8'b1000_0000
   } ana_state_type;

   ana_state_type                 state_ff, state_in;
   logic [CNT_W-1:0]              ch_ff, ch_in;
   logic [SCAN_W-1:0]             j_ff, j_in;
   logic                          pass2_ff, pass2_in;
   logic signed [SAMPLE_BITS-1:0] hi_ff, hi_in, lo_ff, lo_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [CNT_W-1:0]              hist_ff [omwc_pkg::START_SPAN];
   logic [CNT_W-1:0]              hist_in [omwc_pkg::START_SPAN];
   logic [SPAN_W-1:0]             bb_ff, bb_in;
   logic [CNT_W-1:0]              cum_ff, cum_in;
   logic [omwc_pkg::START_W-1:0]  start_ff, start_in;
   logic                          found_ff, found_in;

   logic [LEN_W-1:0]              scan_wide;
   logic [SCAN_W-1:0]             scan;
   logic [CNT_W-1:0]              watched;
   logic [SAMPLE_BITS-1:0]        range;
   logic [SCAN_W-1:0]             onset;
   logic [CNT_W-1:0]              cum_next;
   logic                          crossed;

   // scan cut to the record, watched cut to the store rows
   assign scan_wide = (LEN_W'(cfg.scan_length) > loaded_length) ?
                      loaded_length : LEN_W'(cfg.scan_length);
   assign scan      = SCAN_W'(scan_wide);
   assign watched   = (32'(cfg.channels_watched) > CHANNELS) ?
                      CNT_W'(CHANNELS) : CNT_W'(cfg.channels_watched);

   assign range    = SAMPLE_BITS'(hi_ff - lo_ff);
   assign onset    = j_ff - SCAN_W'(1);
   assign cum_next = cum_ff + hist_ff[bb_ff];
   assign crossed  = PROD_W'({range, 8'h00}) > prod_ff;

   always_comb begin
      state_in = state_ff;
      ch_in    = ch_ff;
      j_in     = j_ff;
      pass2_in = pass2_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      prod_in  = prod_ff;
      hist_in  = hist_ff;
      bb_in    = bb_ff;
      cum_in   = cum_ff;
      start_in = start_ff;
      found_in = found_ff;
      rd_en    = 1'b0;
      rd_addr  = {CH_W'(ch_ff), COL_W'(j_ff)};
      case (state_ff)
         A_IDLE: begin
            if (start) begin
               for (int i = 0; i < omwc_pkg::START_SPAN; i++) begin
                  hist_in[i] = '0;
               end
               ch_in    = '0;
               state_in = A_CHAN;
            end
         end
         A_CHAN: begin
            if (ch_ff >= watched) begin
               bb_in    = '0;
               cum_in   = '0;
               start_in = '0;
               found_in = 1'b0;
               state_in = A_SWEEP;
            end else if (scan < SCAN_W'(2)) begin
               ch_in = ch_ff + CNT_W'(1);
            end else begin
               j_in     = '0;
               pass2_in = 1'b0;
               state_in = A_READ;
            end
         end
         A_READ: begin
            rd_en    = 1'b1;
            state_in = A_UPDATE;
         end
         A_UPDATE: begin
            if (j_ff == '0) begin
               hi_in = rd_data;
               lo_in = rd_data;
            end else begin
               if (rd_data > hi_ff) hi_in = rd_data;
               if (rd_data < lo_ff) lo_in = rd_data;
            end
            state_in = A_NEXT;
         end
         A_NEXT: begin
            if (pass2_ff && (j_ff != '0) && crossed) begin
               // channel begins one before the crossing sample
               if (32'(onset) < omwc_pkg::START_SPAN) begin
                  hist_in[SPAN_W'(onset)] = hist_ff[SPAN_W'(onset)] + CNT_W'(1);
               end
               ch_in    = ch_ff + CNT_W'(1);
               state_in = A_CHAN;
            end else if (j_ff == scan - SCAN_W'(1)) begin
               if (!pass2_ff) begin
                  state_in = A_SCALE;
               end else begin
                  ch_in    = ch_ff + CNT_W'(1);
                  state_in = A_CHAN;
               end
            end else begin
               j_in     = j_ff + SCAN_W'(1);
               state_in = A_READ;
            end
         end
         A_SCALE: begin
            prod_in  = PROD_W'(cfg.threshold_fraction) * PROD_W'(range);
            pass2_in = 1'b1;
            j_in     = '0;
            state_in = A_READ;
         end
         A_SWEEP: begin
            cum_in = cum_next;
            if (32'(cum_next) >= 32'(cfg.channels_needed)) begin
               start_in = omwc_pkg::START_W'(bb_ff);
               found_in = 1'b1;
               state_in = A_DONE;
            end else if (bb_ff == SPAN_W'(omwc_pkg::START_SPAN - 1)) begin
               state_in = A_DONE;
            end else begin
               bb_in = bb_ff + SPAN_W'(1);
            end
         end
         A_DONE: begin
            state_in = A_IDLE;
         end
         default: begin
            state_in = A_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         start_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff    <= ch_in;
      j_ff     <= j_in;
      pass2_ff <= pass2_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      prod_ff  <= prod_in;
      hist_ff  <= hist_in;
      bb_ff    <= bb_in;
      cum_ff   <= cum_in;
   end

   assign status.busy  = state_ff != A_IDLE;
   assign status.done  = state_ff == A_DONE;
   assign status.found = found_ff;
   assign status.start = start_ff;

endmodule

/* rtl/multichannel_onset_window_capture.sv */
// Top level of the multichannel onset window capture block: CSRs, request
// control, result register. Uses omwc_pkg, omwc_store and omwc_analyzer.
//
//  channel  dir  ports                         carries
//  req      in   req_tvalid/tready/tdata/      load or window read request
//                tuser(opcode)/tlast(end)
//  rsp      out  rsp_tvalid/tready/tdata/      analysis result or window sample
//                tuser(result_kind)
//  csr      in   csr_psel/penable/pwrite/...   five config registers, 4-byte step
//
// Load without end flag: written to the store, no result. Read: accepted, then the
// registered store read passes through read wait and deliver to the free result register.
// Record end: analysis sequencer, a range pass and an onset pass per watched channel
// (each store read through the read, update and next states), then the start sweep.
// Requests are taken only while no request is in flight; a load can be taken
// while the previous result still waits in the output register.
// Synchronous reset clears control; the sample store is not cleared.
module multichannel_onset_window_capture #(
   parameter int CHANNELS    = omwc_pkg::CHANNELS_DEF,
   parameter int STORE_DEPTH = omwc_pkg::STORE_DEPTH_DEF,
   parameter int SAMPLE_BITS = omwc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // channel[3:0], position[9:4],
                                                          // sample_in[25:10], zero fill
   input  logic                              req_tuser,  // opcode
   input  logic                              req_tlast,  // end_of_record
   // result
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // window_start[4:0], start_found[5],
                                                          // sample_out[21:6], in_range[22]
   output logic                              rsp_tuser,  // result_kind
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [omwc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [omwc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [omwc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   localparam int CH_W   = $clog2(CHANNELS);
   localparam int COL_W  = $clog2(STORE_DEPTH);
   localparam int ADDR_W = CH_W + COL_W;
   localparam int LEN_W  = omwc_pkg::LEN_W;
   localparam int IO_W   = omwc_pkg::IO_SAMPLE_W;

   typedef enum logic [3:0] {
      ST_IDLE      = 4'b0001,
      ST_READ_WAIT = 4'b0010,
      ST_ANALYZE   = 4'b0100,
      ST_DELIVER   = 4'b1000
   } top_state_type;

   // ---------------- configuration registers ----------------
   omwc_pkg::cfg_type                 cfg_ff, cfg_in;
   logic [omwc_pkg::REG_IDX_W-1:0]    csr_idx;
   logic                              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            omwc_pkg::REG_THRESHOLD:
               cfg_in.threshold_fraction = csr_pwdata[omwc_pkg::THR_W-1:0];
            omwc_pkg::REG_SCAN:    cfg_in.scan_length      = csr_pwdata[omwc_pkg::SCAN_W-1:0];
            omwc_pkg::REG_WINDOW:  cfg_in.window_length    = csr_pwdata[omwc_pkg::WIN_W-1:0];
            omwc_pkg::REG_WATCHED: cfg_in.channels_watched = csr_pwdata[omwc_pkg::CHN_W-1:0];
            omwc_pkg::REG_NEEDED:  cfg_in.channels_needed  = csr_pwdata[omwc_pkg::CHN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         omwc_pkg::REG_THRESHOLD: csr_prdata = 32'(cfg_ff.threshold_fraction);
         omwc_pkg::REG_SCAN:      csr_prdata = 32'(cfg_ff.scan_length);
         omwc_pkg::REG_WINDOW:    csr_prdata = 32'(cfg_ff.window_length);
         omwc_pkg::REG_WATCHED:   csr_prdata = 32'(cfg_ff.channels_watched);
         omwc_pkg::REG_NEEDED:    csr_prdata = 32'(cfg_ff.channels_needed);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_fraction <= omwc_pkg::THR_RESET;
         cfg_ff.scan_length        <= omwc_pkg::SCAN_RESET;
         cfg_ff.window_length      <= omwc_pkg::WIN_RESET;
         cfg_ff.channels_watched   <= omwc_pkg::WATCHED_RESET;
         cfg_ff.channels_needed    <= omwc_pkg::NEEDED_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- request decode ----------------
   logic [omwc_pkg::CHN_W-1:0]    req_channel;
   logic [omwc_pkg::POS_W-1:0]    req_position;
   logic signed [IO_W-1:0]        req_sample;
   logic                          req_fire, fire_load, fire_read;

   assign req_channel  = req_tdata[3:0];
   assign req_position = req_tdata[9:4];
   assign req_sample   = req_tdata[25:10];

   top_state_type                 state_ff, state_in;
   logic [LEN_W-1:0]              len_ff, len_in;
   logic                          ok_ff, ok_in;
   logic                          kind_ff, kind_in;

   assign req_tready = state_ff == ST_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign fire_load  = req_fire && (req_tuser == omwc_pkg::OP_LOAD);
   assign fire_read  = req_fire && (req_tuser == omwc_pkg::OP_READ);

   // load: drop samples outside the store
   logic                          wr_en;
   logic [ADDR_W-1:0]             wr_addr;
   logic signed [SAMPLE_BITS-1:0] wr_data;
   logic [LEN_W-1:0]              pos_plus;

   assign wr_en    = fire_load && (32'(req_channel) < CHANNELS) &&
                     (32'(req_position) < STORE_DEPTH);
   assign wr_addr  = {CH_W'(req_channel), COL_W'(req_position)};
   assign wr_data  = SAMPLE_BITS'(req_sample);   // sign-extend or wrap
   assign pos_plus = LEN_W'(req_position) + LEN_W'(1);

   // read: window start plus offset, checked against record and window
   omwc_pkg::ana_status_type      ana_stat;
   logic [LEN_W-1:0]              read_idx;
   logic                          read_ok;
   logic [ADDR_W-1:0]             read_addr;

   assign read_idx  = LEN_W'(ana_stat.start) + LEN_W'(req_position);
   assign read_ok   = ana_stat.found && (32'(req_channel) < CHANNELS) &&
                      (req_position < cfg_ff.window_length) && (read_idx < len_ff) &&
                      (32'(read_idx) < STORE_DEPTH);
   assign read_addr = {CH_W'(req_channel), COL_W'(read_idx)};

   // ---------------- store and analyzer ----------------
   logic                          ana_start;
   logic                          ana_rd_en;
   logic [ADDR_W-1:0]             ana_rd_addr;
   logic                          mem_rd_en;
   logic [ADDR_W-1:0]             mem_rd_addr;
   logic signed [SAMPLE_BITS-1:0] mem_rd_data;

   assign ana_start   = fire_load && req_tlast;
   assign mem_rd_en   = ana_rd_en || fire_read;
   assign mem_rd_addr = fire_read ? read_addr : ana_rd_addr;

   omwc_store #(
      .CHANNELS    (CHANNELS),
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   omwc_analyzer #(
      .CHANNELS    (CHANNELS),
      .STORE_DEPTH (STORE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_analyzer (
      .clock         (clock),
      .reset         (reset),
      .start         (ana_start),
      .cfg           (cfg_ff),
      .loaded_length (len_ff),
      .rd_en         (ana_rd_en),
      .rd_addr       (ana_rd_addr),
      .rd_data       (mem_rd_data),
      .status        (ana_stat)
   );

   // ---------------- sequencing ----------------
   logic                          out_free;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [23:0]                   rsp_data_ff, rsp_data_in;
   logic                          rsp_kind_ff, rsp_kind_in;
   logic [IO_W-1:0]               sample_out;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign sample_out = ok_ff ? IO_W'(mem_rd_data) : '0;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      ok_in        = ok_ff;
      kind_in      = kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ana_start) begin
               // record closes even if its last sample was dropped
               len_in   = (32'(pos_plus) > STORE_DEPTH) ? LEN_W'(STORE_DEPTH) : pos_plus;
               ok_in    = 1'b0;
               kind_in  = omwc_pkg::KIND_ANALYSIS;
               state_in = ST_ANALYZE;
            end else if (fire_read) begin
               ok_in    = read_ok;
               kind_in  = omwc_pkg::KIND_READ;
               state_in = ST_READ_WAIT;
            end
         end
         ST_READ_WAIT: begin
            state_in = ST_DELIVER;
         end
         ST_ANALYZE: begin
            if (ana_stat.done) state_in = ST_DELIVER;
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               rsp_data_in  = {1'b0, ok_ff, sample_out, ana_stat.found, ana_stat.start};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      kind_ff     <= kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // ---------------- assertions ----------------
   // analyzer finishes only while the top waits for it
   a_done_in_analyze: assert property (@(posedge clock) disable iff (reset)
      ana_stat.done |-> state_ff == ST_ANALYZE)
      else $error("analysis done outside analyze state");

   // store write port never collides with an analysis scan
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !ana_stat.busy)
      else $error("store written while analysis runs");

   // an accepted read goes to the read-wait state next, to wait for store data
   a_read_wait: assert property (@(posedge clock) disable iff (reset)
      fire_read |=> state_ff == ST_READ_WAIT)
      else $error("read request did not enter read wait");

   // a sample is only flagged in range when a start was found
   a_range_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[5] && rsp_tuser == omwc_pkg::KIND_READ)
      else $error("in_range set without a found start");

endmodule
